>>> rtl/tfdst_pkg.sv
// ----------------------------------------------------------------------------
// tfdst_pkg: shared types and constants
// Record layout, result kinds and controller states for the touch frame
// decoder.
// ----------------------------------------------------------------------------
package tfdst_pkg;

	localparam int PKT_LEN   = 9;
	localparam int CNT_W     = 4;
	localparam int ID_W      = 4;
	localparam int NUM_SLOTS = 15;
	localparam int POS_W     = $clog2(PKT_LEN);
	localparam int PKT_IDX_W = 3;

	localparam logic [1:0] KIND_PRESS   = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_SYNC    = 2'd2;

	localparam logic [7:0] LO_NIB = 8'h0f;
	localparam logic [7:0] HI_NIB = 8'hf0;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [11:0]     x;
		logic [11:0]     y;
		logic [7:0]      z;
	} touch_rec_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEC0,
		ST_DEC1,
		ST_RD,
		ST_EVAL,
		ST_REL,
		ST_SYNC
	} tfd_state_t;

endpackage

>>> rtl/touch_frame_decode_slot_tracker_unit.sv
// ----------------------------------------------------------------------------
// touch_frame_decode_slot_tracker_unit: touch frame decoder with slot tracking
// Collects a count byte and nine-byte packets, stores decoded touch records in
// a small synchronous memory and emits press, release and sync reports.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: a transaction is taken on a rising edge with start high and
//   busy low. op = 0 carries the count byte that opens a frame, op = 1 a
//   packet data byte. Data bytes with no frame open are dropped.
//   Result channel: each report sits on kind/slot/pos_x/pos_y/pressure/last
//   for exactly one cycle with valid high. The receiver cannot stall it.
// Sequence:
//   A nonzero count byte or a mid-packet data byte leaves busy low. The ninth
//   byte of a packet raises busy while both records are written into the touch
//   memory (one write port). When that packet completes the frame, the block
//   walks the memory record by record (address, then registered read data),
//   then walks the 15 slots for releases at one slot a cycle, then sends the
//   sync. A count of zero goes straight to the release walk.
//   Reports are registered and appear in the cycle after the controller step
//   that forms them.
// Reset:
//   arst_n clears the controller, slot mask, counters and output strobe.
//   The touch memory and packet bytes are not cleared; entries are read only
//   after being written in the same frame.
// ----------------------------------------------------------------------------
module touch_frame_decode_slot_tracker_unit #(
	parameter int MAX_TOUCHES = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [7:0]  byte_in,
	output logic        valid,
	output logic [1:0]  kind,
	output logic [3:0]  slot,
	output logic [11:0] pos_x,
	output logic [11:0] pos_y,
	output logic [7:0]  pressure,
	output logic        last
);
	import tfdst_pkg::*;

	localparam int AW = (MAX_TOUCHES > 1) ? $clog2(MAX_TOUCHES) : 1;
	localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_TOUCHES);

	tfd_state_t state_q, state_d;

	// frame bookkeeping
	logic [CNT_W-1:0]     count_q;      // zero: no frame pending
	logic [POS_W-1:0]     pos_q;        // byte position inside packet
	logic [PKT_IDX_W-1:0] pkt_q;        // packet index inside frame
	logic                 zero_id_q;
	logic [NUM_SLOTS-1:0] active_q;     // slots held by the last frame
	logic [NUM_SLOTS-1:0] mask_q;       // slots pressed in this frame
	logic [CNT_W-1:0]     idx_q;        // walk counter (records, then slots)
	logic [7:0]           pkt_bytes [PKT_LEN];

	// touch memory
	touch_rec_t mem [MAX_TOUCHES];
	touch_rec_t rd_q;
	logic       mem_we;
	logic [AW-1:0] mem_waddr;
	touch_rec_t mem_wdata;
	logic       mem_re;

	// input transaction
	logic accept;
	logic [CNT_W-1:0] nib, clamp_cnt;

	// record decode
	logic [CNT_W-1:0] rec0_idx, rec1_idx;
	touch_rec_t rec0, rec1;
	logic frame_done;

	// report forming
	logic       emit;
	logic [1:0] emit_kind;
	logic [3:0] emit_slot;
	logic [11:0] emit_x, emit_y;
	logic [7:0] emit_z;
	logic       emit_last;
	logic       press_ok;
	logic [NUM_SLOTS-1:0] gone;

	// output registers
	logic        valid_q;
	logic [1:0]  kind_q;
	logic [3:0]  slot_q;
	logic [11:0] x_q, y_q;
	logic [7:0]  z_q;
	logic        last_q;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign nib       = CNT_W'(byte_in & LO_NIB);
	assign clamp_cnt = (nib > MAX_C) ? MAX_C : nib;

	assign rec0_idx = {pkt_q, 1'b0};
	assign rec1_idx = {pkt_q, 1'b1};

	always_comb begin
		rec0.id = ID_W'(pkt_bytes[0] & LO_NIB);
		rec0.x  = {pkt_bytes[3][3:0], pkt_bytes[1]};
		rec0.y  = {pkt_bytes[3][7:4], pkt_bytes[2]};
		rec0.z  = pkt_bytes[4];
		rec1.id = ID_W'((pkt_bytes[0] & HI_NIB) >> 4);
		rec1.x  = {pkt_bytes[7][3:0], pkt_bytes[5]};
		rec1.y  = {pkt_bytes[7][7:4], pkt_bytes[6]};
		rec1.z  = pkt_bytes[8];
	end

	// the frame ends with the packet that holds the last needed record
	assign frame_done = ({1'b0, rec0_idx} + 5'd2) >= {1'b0, count_q};

	// id 0 never reports; once an id 0 was seen, id 1 is skipped too
	assign press_ok = (rd_q.id != '0) && !(zero_id_q && rd_q.id == ID_W'(1));
	assign gone     = active_q & ~mask_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!op && clamp_cnt == '0)
						state_d = ST_REL;
					else if (op && count_q != '0 && pos_q == POS_W'(PKT_LEN - 1))
						state_d = ST_DEC0;
				end
			end
			ST_DEC0: state_d = ST_DEC1;
			ST_DEC1: state_d = frame_done ? ST_RD : ST_IDLE;
			ST_RD:   state_d = ST_EVAL;
			ST_EVAL: state_d = ((idx_q + 1'b1) == count_q) ? ST_REL : ST_RD;
			ST_REL:  state_d = (idx_q == CNT_W'(NUM_SLOTS - 1)) ? ST_SYNC : ST_REL;
			ST_SYNC: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// memory port and report outputs
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = rec0_idx[AW-1:0];
		mem_wdata = rec0;
		mem_re    = 1'b0;
		emit      = 1'b0;
		emit_kind = KIND_PRESS;
		emit_slot = '0;
		emit_x    = '0;
		emit_y    = '0;
		emit_z    = '0;
		emit_last = 1'b0;
		case (state_q)
			ST_DEC0: begin
				mem_we    = (rec0_idx < count_q);
				mem_waddr = rec0_idx[AW-1:0];
				mem_wdata = rec0;
			end
			ST_DEC1: begin
				mem_we    = (rec1_idx < count_q);
				mem_waddr = rec1_idx[AW-1:0];
				mem_wdata = rec1;
			end
			ST_RD: mem_re = 1'b1;
			ST_EVAL: begin
				emit      = press_ok;
				emit_kind = KIND_PRESS;
				emit_slot = rd_q.id - 1'b1;
				emit_x    = rd_q.x;
				emit_y    = rd_q.y;
				emit_z    = rd_q.z;
			end
			ST_REL: begin
				emit      = gone[idx_q];
				emit_kind = KIND_RELEASE;
				emit_slot = idx_q;
			end
			ST_SYNC: begin
				emit      = 1'b1;
				emit_kind = KIND_SYNC;
				emit_last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rd_q <= mem[idx_q[AW-1:0]];
	end

	// packet bytes land at the current position
	always_ff @(posedge clk) begin
		if (accept && op && count_q != '0)
			pkt_bytes[pos_q] <= byte_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			pos_q     <= '0;
			pkt_q     <= '0;
			zero_id_q <= 1'b0;
			active_q  <= '0;
			mask_q    <= '0;
			idx_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!op) begin
							count_q   <= clamp_cnt;
							pos_q     <= '0;
							pkt_q     <= '0;
							zero_id_q <= 1'b0;
							mask_q    <= '0;
							idx_q     <= '0;
						end else if (count_q != '0) begin
							if (pos_q == POS_W'(PKT_LEN - 1))
								pos_q <= '0;
							else
								pos_q <= pos_q + 1'b1;
						end
					end
				end
				ST_DEC0: begin
					if (rec0_idx < count_q && rec0.id == '0)
						zero_id_q <= 1'b1;
				end
				ST_DEC1: begin
					if (rec1_idx < count_q && rec1.id == '0)
						zero_id_q <= 1'b1;
					pkt_q  <= pkt_q + 1'b1;
					idx_q  <= '0;
					mask_q <= '0;
				end
				ST_EVAL: begin
					if (press_ok)
						mask_q[emit_slot] <= 1'b1;
					if ((idx_q + 1'b1) == count_q)
						idx_q <= '0;
					else
						idx_q <= idx_q + 1'b1;
				end
				ST_REL: idx_q <= idx_q + 1'b1;
				ST_SYNC: begin
					active_q  <= mask_q;
					count_q   <= '0;
					pos_q     <= '0;
					pkt_q     <= '0;
					zero_id_q <= 1'b0;
					idx_q     <= '0;
				end
				default: ;
			endcase
		end
	end

	// report register: one-cycle strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else
			valid_q <= emit;
	end

	always_ff @(posedge clk) begin
		kind_q <= emit_kind;
		slot_q <= emit_slot;
		x_q    <= emit_x;
		y_q    <= emit_y;
		z_q    <= emit_z;
		last_q <= emit_last;
	end

	assign valid    = valid_q;
	assign kind     = kind_q;
	assign slot     = slot_q;
	assign pos_x    = x_q;
	assign pos_y    = y_q;
	assign pressure = z_q;
	assign last     = last_q;

	// --------------------------------------------------------------------
	// Assertions
	// --------------------------------------------------------------------

	// records are only written inside the current frame's count
	a_write_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ((state_q == ST_DEC0 && rec0_idx < count_q) ||
			(state_q == ST_DEC1 && rec1_idx < count_q)))
		else $error("touch memory write outside the frame");

	// a press report's slot is marked in the frame mask
	a_press_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && kind == KIND_PRESS) |-> mask_q[slot])
		else $error("press report slot not recorded in mask");

	// a release is only sent for a slot held before and not pressed now
	a_release_gone: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && kind == KIND_RELEASE) |-> (active_q[slot] && !mask_q[slot]))
		else $error("release for a slot that is not gone");

	// the sync report closes the frame and commits the slot mask
	a_sync_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && last) |-> (active_q == mask_q && count_q == '0 && !busy))
		else $error("sync without frame commit");

endmodule

>>> test/touch_frame_decode_slot_tracker_unit_test.sv
// ----------------------------------------------------------------------------
// touch_frame_decode_slot_tracker_unit_test: self-checking bench for the decoder
// Feeds count and packet bytes through the start/busy channel, mirrors the
// frame decode and slot tracking in a behavioral predictor, and compares every
// press, release and sync report in order against the predicted ones.
// ----------------------------------------------------------------------------
module touch_frame_decode_slot_tracker_unit_test;
	import tfdst_pkg::*;

	localparam int MAX_TOUCHES  = 10;
	// Longest quiet stretch: a sender gap plus a full 10-record frame walk.
	// STALL_LIMIT is many times that.
	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 60;
	localparam int RANDOM_ITEMS = 20;

	localparam logic OP_COUNT = 1'b0;
	localparam logic OP_DATA  = 1'b1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  slot;
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic [7:0]  pressure;
		logic        last;
	} report_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        op;
	logic [7:0]  byte_in;
	logic        valid;
	logic [1:0]  kind;
	logic [3:0]  slot;
	logic [11:0] pos_x;
	logic [11:0] pos_y;
	logic [7:0]  pressure;
	logic        last;

	// Predictor state: decoded records, the packet being collected, the
	// slot mask carried between frames and the frame bookkeeping.
	touch_rec_t           rec_mem [MAX_TOUCHES];
	logic [7:0]           pkt_buf [PKT_LEN];
	logic [NUM_SLOTS-1:0] slot_mask = '0;
	int unsigned          frame_count = 0;
	int unsigned          frame_pos = 0;
	logic                 saw_zero_id = 1'b0;
	report_t              pending_reports [$];

	int errors = 0;
	int stall_cycles = 0;
	int sent_items = 0;
	bit gaps_on = 1'b1;

	touch_frame_decode_slot_tracker_unit #(
		.MAX_TOUCHES(MAX_TOUCHES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.byte_in(byte_in),
		.valid(valid),
		.kind(kind),
		.slot(slot),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pressure(pressure),
		.last(last)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// Decode one half of a completed packet into the record store. Records
	// beyond the frame count (the unused half of an odd frame) are dropped
	// and do not count as a zero id.
	task automatic store_record(input int unsigned idx, input bit upper);
		int unsigned base;
		touch_rec_t  rec;
		if (idx < MAX_TOUCHES && idx < frame_count) begin
			base     = upper ? 4 : 0;
			rec.id   = upper ? pkt_buf[0][7:4] : pkt_buf[0][3:0];
			rec.x    = {pkt_buf[base+3][3:0], pkt_buf[base+1]};
			rec.y    = {pkt_buf[base+3][7:4], pkt_buf[base+2]};
			rec.z    = pkt_buf[base+4];
			if (rec.id == 0)
				saw_zero_id = 1'b1;
			rec_mem[idx] = rec;
		end
	endtask

	// Frame end: presses in record order, releases for slots that dropped
	// out in ascending order, then the sync. A zero id anywhere in the frame
	// also suppresses id 1.
	task automatic emit_frame_reports();
		logic [NUM_SLOTS-1:0] pressed;
		logic [ID_W-1:0]      skip_id;
		report_t              rpt;
		pressed = '0;
		skip_id = saw_zero_id ? 4'd1 : 4'd0;
		for (int i = 0; i < frame_count; i++) begin
			if (rec_mem[i].id != 0 && rec_mem[i].id != skip_id) begin
				rpt = '{kind: KIND_PRESS, slot: rec_mem[i].id - 4'd1,
					pos_x: rec_mem[i].x, pos_y: rec_mem[i].y,
					pressure: rec_mem[i].z, last: 1'b0};
				pending_reports.push_back(rpt);
				pressed[rec_mem[i].id - 4'd1] = 1'b1;
			end
		end
		for (int s = 0; s < NUM_SLOTS; s++) begin
			if (slot_mask[s] && !pressed[s]) begin
				rpt = '{kind: KIND_RELEASE, slot: 4'(s), pos_x: '0, pos_y: '0,
					pressure: '0, last: 1'b0};
				pending_reports.push_back(rpt);
			end
		end
		rpt = '{kind: KIND_SYNC, slot: '0, pos_x: '0, pos_y: '0,
			pressure: '0, last: 1'b1};
		pending_reports.push_back(rpt);
		slot_mask   = pressed;
		frame_count = 0;
		frame_pos   = 0;
		saw_zero_id = 1'b0;
	endtask

	// Advance the predictor by one accepted transaction.
	task automatic predict_transaction(input logic is_data, input logic [7:0] b);
		int unsigned cnt;
		int unsigned needed;
		int unsigned pkt_idx;
		if (is_data == OP_COUNT) begin
			// A count byte always restarts; any partial frame is lost.
			cnt = b & LO_NIB;
			if (cnt > MAX_TOUCHES)
				cnt = MAX_TOUCHES;
			frame_count = cnt;
			frame_pos   = 0;
			saw_zero_id = 1'b0;
			if (cnt == 0)
				emit_frame_reports();
		end else if (frame_count != 0) begin
			pkt_buf[frame_pos % PKT_LEN] = b;
			frame_pos++;
			if (frame_pos % PKT_LEN == 0) begin
				pkt_idx = frame_pos / PKT_LEN - 1;
				store_record(2 * pkt_idx, 1'b0);
				store_record(2 * pkt_idx + 1, 1'b1);
			end
			needed = ((frame_count + 1) / 2) * PKT_LEN;
			if (frame_pos >= needed)
				emit_frame_reports();
		end
	endtask

	// ------------------------------------------------------------------------
	// Checker
	// ------------------------------------------------------------------------

	function automatic void check_field(string name, int unsigned exp_v,
		int unsigned got_v);
		if (exp_v != got_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h",
				$time, name, exp_v, got_v);
		end
	endfunction

	task automatic check_report();
		report_t want;
		if (pending_reports.size() == 0) begin
			errors++;
			$display("%0t: report with none expected, expected none, actual kind %0d slot %0d",
				$time, kind, slot);
		end else begin
			want = pending_reports.pop_front();
			check_field("kind", want.kind, kind);
			check_field("slot", want.slot, slot);
			check_field("pos_x", want.pos_x, pos_x);
			check_field("pos_y", want.pos_y, pos_y);
			check_field("pressure", want.pressure, pressure);
			check_field("last", want.last, last);
		end
	endtask

	// Both channels are observed at the rising edge. The result is checked
	// before the new transaction is predicted: a report never comes from a
	// byte taken on the same edge, and this keeps a stray report from being
	// matched against a freshly queued expectation.
	always @(posedge clk) begin
		if (arst_n && valid)
			check_report();
		if (arst_n && start && !busy)
			predict_transaction(op, byte_in);
		if (arst_n && ((start && !busy) || valid))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("touch_frame_decode_slot_tracker_unit_test NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Driver
	// ------------------------------------------------------------------------

	// Sender gap with garbage on the payload while start is low.
	task automatic idle_burst();
		int n;
		n = $urandom_range(1, 16);
		@(negedge clk);
		start   <= 1'b0;
		op      <= 1'($urandom);
		byte_in <= 8'($urandom);
		repeat (n - 1) @(negedge clk);
	endtask

	// One transaction: drive at the falling edge, hold until taken. start is
	// left high so a following byte can go out back to back.
	task automatic send_byte(input logic is_data, input logic [7:0] b);
		if (gaps_on && $urandom_range(0, 3) == 0)
			idle_burst();
		@(negedge clk);
		start   <= 1'b1;
		op      <= is_data;
		byte_in <= b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent_items++;
	endtask

	// Hold the sender off until every predicted report has come out.
	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending_reports.size() != 0)
			@(negedge clk);
	endtask

	function automatic int unsigned clamp_count(input logic [7:0] cnt_byte);
		int unsigned n;
		n = cnt_byte[3:0];
		return (n > MAX_TOUCHES) ? MAX_TOUCHES : n;
	endfunction

	// Ids lean toward the interesting values: zero, one, then the rest.
	function automatic logic [3:0] pick_id();
		int r;
		r = $urandom_range(0, 15);
		if (r < 2)
			return 4'd0;
		if (r < 4)
			return 4'd1;
		return 4'($urandom_range(2, 15));
	endfunction

	function automatic logic [3:0] pick_count();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 4'd0;
		if (r < 7)
			return 4'($urandom_range(1, 4));
		if (r < 9)
			return 4'($urandom_range(5, 10));
		return 4'($urandom_range(11, 15));
	endfunction

	task automatic send_packet(input logic [3:0] id_lo, input logic [3:0] id_hi);
		send_byte(OP_DATA, {id_hi, id_lo});
		repeat (8)
			send_byte(OP_DATA, 8'($urandom));
	endtask

	// Complete frame with random records.
	task automatic send_frame(input logic [7:0] cnt_byte);
		int unsigned n;
		n = clamp_count(cnt_byte);
		send_byte(OP_COUNT, cnt_byte);
		for (int p = 0; p < (n + 1) / 2; p++)
			send_packet(pick_id(), pick_id());
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Zero counts with an empty mask give a bare sync; the high nibble of the
	// count byte is don't-care.
	task automatic test_empty_frames();
		send_byte(OP_COUNT, 8'h00);
		send_byte(OP_COUNT, 8'hF0);
	endtask

	// Data with no frame open is dropped silently.
	task automatic test_stray_data();
		send_byte(OP_DATA, 8'h00);
		send_byte(OP_DATA, 8'hFF);
	endtask

	// Lowest and highest ids with all-ones and all-zero fields, then an odd
	// frame whose unused second record carries id 0 and all-ones data, then a
	// zero count that releases whatever is left.
	task automatic test_extreme_records();
		send_byte(OP_COUNT, 8'h02);
		send_byte(OP_DATA, 8'hF1);
		repeat (4)
			send_byte(OP_DATA, 8'hFF);
		repeat (4)
			send_byte(OP_DATA, 8'h00);
		send_byte(OP_COUNT, 8'h01);
		send_byte(OP_DATA, 8'h0F);
		repeat (4)
			send_byte(OP_DATA, 8'h00);
		repeat (4)
			send_byte(OP_DATA, 8'hFF);
		send_byte(OP_COUNT, 8'h00);
	endtask

	// A zero id in the frame hides id 1 as well; without one, id 1 presses.
	task automatic test_zero_id();
		send_byte(OP_COUNT, 8'h03);
		send_packet(4'd0, 4'd5);
		send_packet(4'd1, 4'd1);
		send_byte(OP_COUNT, 8'h02);
		send_packet(4'd1, 4'd2);
	endtask

	// Same id on several records: one press each, one mask bit.
	task automatic test_duplicate_ids();
		send_byte(OP_COUNT, 8'h04);
		send_packet(4'd7, 4'd7);
		send_packet(4'd7, 4'd3);
	endtask

	// A count byte in mid-frame drops the partial frame, including one whose
	// first packet has already been decoded.
	task automatic test_restart();
		send_byte(OP_COUNT, 8'h02);
		repeat (5)
			send_byte(OP_DATA, 8'($urandom));
		send_byte(OP_COUNT, 8'h04);
		send_packet(pick_id(), pick_id());
		send_byte(OP_COUNT, 8'h31);
		send_frame(8'h02);
	endtask

	// Largest frame, reached through a count above the limit that clamps to it.
	task automatic test_full_frame();
		send_frame(8'hFF);
	endtask

	// Mostly well-formed frames with random content; the rest are cut-off
	// frames, stray bytes and frames sent only after the pipe has drained.
	task automatic test_random_frames(input int target);
		int          first_item;
		int          pick;
		int unsigned needed;
		logic [7:0]  cnt_byte;
		first_item = sent_items;
		while (sent_items - first_item < target) begin
			pick = $urandom_range(0, 99);
			cnt_byte = 8'($urandom);
			cnt_byte[3:0] = pick_count();
			if (pick < 70) begin
				send_frame(cnt_byte);
			end else if (pick < 80) begin
				cnt_byte[3:0] = 4'($urandom_range(1, 10));
				needed = ((clamp_count(cnt_byte) + 1) / 2) * PKT_LEN;
				send_byte(OP_COUNT, cnt_byte);
				repeat ($urandom_range(0, needed - 1))
					send_byte(OP_DATA, 8'($urandom));
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 3))
					send_byte(OP_DATA, 8'($urandom));
			end else begin
				wait_drained();
				send_frame(cnt_byte);
			end
		end
	endtask

	// Closing stretch with no sender gaps at all.
	task automatic test_back_to_back();
		logic [7:0] cnt_byte;
		gaps_on = 1'b0;
		repeat (2) begin
			cnt_byte = 8'($urandom);
			cnt_byte[3:0] = pick_count();
			send_frame(cnt_byte);
		end
		send_byte(OP_COUNT, 8'h00);
	endtask

	initial begin
		arst_n  = 1'b0;
		start   = 1'b0;
		op      = 1'b0;
		byte_in = 8'h00;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_frames();
		test_stray_data();
		test_extreme_records();
		test_zero_id();
		test_duplicate_ids();
		test_restart();
		// sender holds off until every report is out at least once here
		wait_drained();
		test_full_frame();
		test_random_frames(RANDOM_ITEMS);
		test_back_to_back();

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("touch_frame_decode_slot_tracker_unit_test OK");
		else
			$display("touch_frame_decode_slot_tracker_unit_test NOT OK");
		$finish;
	end

endmodule
